// File: rtl/isp_pkg.sv
// Shared types and constants for the integer stack machine.
`timescale 1ns / 1ps
package isp_pkg;

   localparam int VALUE_W         = 31;
   localparam int FUNC_W          = 4;
   localparam int LIMIT_W         = 30;
   localparam int STACK_DEPTH_DEF = 1024;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 30'd1000000000;
   localparam logic [VALUE_W-1:0] VALUE_MIN   = 31'h4000_0000;

   typedef enum logic [FUNC_W-1:0] {
      FN_START  = 4'd0,
      FN_NUM    = 4'd1,
      FN_POP    = 4'd2,
      FN_INV    = 4'd3,
      FN_DUP    = 4'd4,
      FN_SWP    = 4'd5,
      FN_ADD    = 4'd6,
      FN_SUB    = 4'd7,
      FN_MUL    = 4'd8,
      FN_DIV    = 4'd9,
      FN_MOD    = 4'd10,
      FN_FINISH = 4'd11
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_TOP,
      ST_READ_NEXT,
      ST_SWAP_WR,
      ST_CHECK,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/integer_stack_machine.sv
// Signed integer stack machine: sequencer, stack RAM, divider and result register.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_func, req_operand
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_result_value, rsp_is_error
//  csr     | in        | csr_valid / csr_ready  | csr_magnitude_limit
//
// One instruction at a time. DIV and MOD wait for the 31-step divider.
// Each sequencer state that reads the stack is bounded by the registered read of the stack RAM.
// Synchronous reset clears the stack count and the error flag and reloads the default limit.
// A FINISH waits in its last state while a previous result is still stalled.
`timescale 1ns / 1ps
module integer_stack_machine import isp_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic signed [VALUE_W-1:0] req_operand,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_result_value,
   output logic                      rsp_is_error,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [LIMIT_W-1:0]        csr_magnitude_limit
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int RW = 2 * VALUE_W;

   state_type state_ff, state_in;

   logic [FUNC_W-1:0]         func_ff, func_in;
   logic signed [VALUE_W-1:0] opnd_ff, opnd_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      err_ff, err_in;
   logic [LIMIT_W-1:0]        limit_ff;
   logic signed [VALUE_W-1:0] top_ff, top_in;
   logic signed [VALUE_W-1:0] nxt_ff, nxt_in;
   logic signed [RW-1:0]      res_ff, res_in;
   logic                      fin_err_ff, fin_err_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                      rsp_err_ff, rsp_err_in;

   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic [VALUE_W-1:0]        ram_wdata;
   logic [AW-1:0]             ram_raddr;
   logic [VALUE_W-1:0]        ram_rdata;
   logic signed [VALUE_W-1:0] rd_s;

   logic                      div_start;
   logic                      div_done;
   logic [VALUE_W-1:0]        div_quo;
   logic [VALUE_W-1:0]        div_rem;
   logic [VALUE_W-1:0]        abs_a;
   logic [VALUE_W-1:0]        abs_b;
   logic                      div_neg;
   logic [VALUE_W-1:0]        div_val;
   logic                      div_bad;

   logic                      accept;
   logic [CW-1:0]             cnt_m1;
   logic [CW-1:0]             cnt_m2;
   logic                      full;
   logic                      known_op;
   logic                      skip;
   logic                      under;
   logic                      out_free;
   logic signed [RW-1:0]      lim_s;
   logic                      over;
   logic signed [RW-1:0]      mul_full;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign cnt_m1 = cnt_ff - CW'(1);
   assign cnt_m2 = cnt_ff - CW'(2);
   assign full   = (cnt_ff == CW'(STACK_DEPTH));
   assign rd_s   = $signed(ram_rdata);

   // ops other than START/FINISH are dropped once the error is set
   assign known_op = (func_ff inside {FN_NUM, FN_POP, FN_INV, FN_DUP, FN_SWP,
                                      FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD});
   assign skip  = !known_op || err_ff;
   assign under = (func_ff inside {FN_POP, FN_INV, FN_DUP}) ? (cnt_ff == '0) :
                  (func_ff == FN_NUM) ? 1'b0 : (cnt_ff < CW'(2));

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign lim_s    = $signed({{(RW - LIMIT_W){1'b0}}, limit_ff});
   assign over     = (res_ff > lim_s) || (res_ff < -lim_s);
   assign mul_full = rd_s * top_ff;

   // divider operand magnitudes; the most negative value maps to 2^30
   assign abs_a   = rd_s[VALUE_W-1] ? VALUE_W'(-rd_s) : ram_rdata;
   assign abs_b   = top_ff[VALUE_W-1] ? VALUE_W'(-top_ff) : top_ff;
   assign div_neg = nxt_ff[VALUE_W-1] ^ top_ff[VALUE_W-1];
   assign div_val = (func_ff == FN_DIV) ? (div_neg ? VALUE_W'(-div_quo) : div_quo) :
                    (nxt_ff[VALUE_W-1] ? VALUE_W'(-div_rem) : div_rem);
   // a positive quotient of 2^30 does not fit
   assign div_bad = (func_ff == FN_DIV) && !div_neg && div_quo[VALUE_W-1];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (func_ff == FN_FINISH) begin
               state_in = ST_READ_TOP;
            end else if (func_ff == FN_START || skip || under ||
                         func_ff == FN_NUM || func_ff == FN_POP) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ_TOP;
            end
         end
         ST_READ_TOP: begin
            if (func_ff == FN_FINISH) begin
               state_in = ST_EMIT;
            end else if (func_ff == FN_INV || func_ff == FN_DUP) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ_NEXT;
            end
         end
         ST_READ_NEXT: begin
            case (func_ff)
               FN_SWP:         state_in = ST_SWAP_WR;
               FN_DIV, FN_MOD: state_in = (top_ff == '0) ? ST_IDLE : ST_DIV_WAIT;
               default:        state_in = ST_CHECK;
            endcase
         end
         ST_SWAP_WR: state_in = ST_IDLE;
         ST_CHECK:   state_in = ST_IDLE;
         ST_DIV_WAIT: begin
            if (div_done) state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      func_in      = func_ff;
      opnd_in      = opnd_ff;
      cnt_in       = cnt_ff;
      err_in       = err_ff;
      top_in       = top_ff;
      nxt_in       = nxt_ff;
      res_in       = res_ff;
      fin_err_in   = fin_err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff[AW-1:0];
      ram_wdata    = opnd_ff;
      ram_raddr    = cnt_m1[AW-1:0];
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in = req_func;
               opnd_in = req_operand;
            end
         end
         ST_DECODE: begin
            if (func_ff == FN_START) begin
               ram_we    = 1'b1;
               ram_waddr = '0;
               cnt_in    = CW'(1);
               err_in    = 1'b0;
            end else if (func_ff == FN_FINISH) begin
               fin_err_in = err_ff || (cnt_ff != CW'(1));
            end else if (!skip) begin
               if (under) begin
                  err_in = 1'b1;
               end else if (func_ff == FN_NUM) begin
                  if (full) begin
                     err_in = 1'b1;
                  end else begin
                     ram_we = 1'b1;
                     cnt_in = cnt_ff + CW'(1);
                  end
               end else if (func_ff == FN_POP) begin
                  cnt_in = cnt_m1;
               end
            end
         end
         ST_READ_TOP: begin
            top_in    = rd_s;
            ram_raddr = cnt_m2[AW-1:0];
            if (func_ff == FN_INV) begin
               if (ram_rdata == VALUE_MIN) begin
                  err_in = 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = cnt_m1[AW-1:0];
                  ram_wdata = VALUE_W'(-rd_s);
               end
            end else if (func_ff == FN_DUP) begin
               if (full) begin
                  err_in = 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata;
                  cnt_in    = cnt_ff + CW'(1);
               end
            end
         end
         ST_READ_NEXT: begin
            nxt_in = rd_s;
            case (func_ff)
               FN_SWP: begin
                  ram_we    = 1'b1;
                  ram_waddr = cnt_m1[AW-1:0];
                  ram_wdata = ram_rdata;
               end
               FN_ADD:  res_in = RW'(rd_s) + RW'(top_ff);
               FN_SUB:  res_in = RW'(rd_s) - RW'(top_ff);
               FN_MUL:  res_in = mul_full;
               FN_DIV, FN_MOD: begin
                  if (top_ff == '0) begin
                     err_in = 1'b1;
                  end else begin
                     div_start = 1'b1;
                  end
               end
               default: res_in = res_ff;
            endcase
         end
         ST_SWAP_WR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_m2[AW-1:0];
            ram_wdata = top_ff;
         end
         ST_CHECK: begin
            if (over) begin
               err_in = 1'b1;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = cnt_m2[AW-1:0];
               ram_wdata = res_ff[VALUE_W-1:0];
               cnt_in    = cnt_m1;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (div_bad) begin
                  err_in = 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = cnt_m2[AW-1:0];
                  ram_wdata = div_val;
                  cnt_in    = cnt_m1;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = fin_err_ff ? '0 : top_ff;
               rsp_err_in   = fin_err_ff;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         err_ff       <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_magnitude_limit;
         end
      end
      func_ff      <= func_in;
      opnd_ff      <= opnd_in;
      top_ff       <= top_in;
      nxt_ff       <= nxt_in;
      res_ff       <= res_in;
      fin_err_ff   <= fin_err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   isp_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   isp_div #(
      .WIDTH (VALUE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (abs_a),
      .divisor   (abs_b),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_is_error     = rsp_err_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (req_func == FN_START) |=> ##1 (cnt_ff == CW'(1)) && !err_ff)
      else $error("START did not leave one entry and a clear error");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (top_ff != '0) && (state_ff == ST_READ_NEXT))
      else $error("divider started with zero divisor");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside FINISH");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff != ST_IDLE) && (state_ff != ST_EMIT))
      else $error("stack write while idle or emitting");

endmodule

// File: rtl/isp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module isp_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/isp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module isp_div import isp_pkg::*; #(
   parameter int WIDTH = VALUE_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int SW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [SW-1:0]    step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   trial;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         step_in = SW'(WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WIDTH]) begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         step_in = step_ff - SW'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the integer stack machine: directed and random programs.
`timescale 1ns / 1ps
module tb_top;
   import isp_pkg::*;

   localparam longint MAX31           = 64'sd1073741823;
   localparam longint MIN31           = -64'sd1073741824;
   localparam int     SETTLE_CYCLES   = 64;
   localparam int     HOLD_OFF_CYCLES = 400;
   localparam int     SAW             = $clog2(STACK_DEPTH_DEF);
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      is_error;
   } finish_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [FUNC_W-1:0]         req_func = FN_START;
   logic signed [VALUE_W-1:0] req_operand = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_result_value;
   logic                      rsp_is_error;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [LIMIT_W-1:0]        csr_magnitude_limit = LIMIT_RESET;

   // shadow copy of the machine state
   logic signed [VALUE_W-1:0] shadow_stack [STACK_DEPTH_DEF];
   int unsigned               shadow_depth = 0;
   bit                        shadow_err = 1'b0;
   logic [LIMIT_W-1:0]        shadow_limit = LIMIT_RESET;

   finish_result_type pending_finish[$];
   int                fail_count = 0;
   int                sender_idle_pct = 0;
   int                receiver_stall_pct = 0;
   int                hold_requests = 0;

   integer_stack_machine #(
      .STACK_DEPTH(STACK_DEPTH_DEF)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_operand        (req_operand),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_value   (rsp_result_value),
      .rsp_is_error       (rsp_is_error),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_magnitude_limit(csr_magnitude_limit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [SAW-1:0] slot(input int unsigned d);
      return d[SAW-1:0];
   endfunction

   function automatic void push_value(input longint v);
      if (shadow_depth >= STACK_DEPTH_DEF) begin
         shadow_err = 1'b1;
      end else begin
         shadow_stack[slot(shadow_depth)] = v[VALUE_W-1:0];
         shadow_depth++;
      end
   endfunction

   function automatic longint pop_value();
      shadow_depth--;
      return shadow_stack[slot(shadow_depth)];
   endfunction

   function automatic void execute_instr(input logic [FUNC_W-1:0] fn,
                                         input logic signed [VALUE_W-1:0] opnd);
      longint            a;
      longint            b;
      longint            r;
      int unsigned       need;
      finish_result_type res;
      case (fn)
         FN_START: begin
            shadow_depth = 0;
            shadow_err   = 1'b0;
            push_value(opnd);
         end
         FN_FINISH: begin
            res.is_error = shadow_err || (shadow_depth != 1);
            res.value    = res.is_error ? '0 : shadow_stack[0];
            pending_finish.insert(pending_finish.size(), res);
         end
         default: begin
            // unknown codes and anything after a sticky error fall through silently
            if (fn <= FN_MOD && !shadow_err) begin
               need = (fn == FN_NUM) ? 0 : (fn <= FN_DUP) ? 1 : 2;
               if (shadow_depth < need) begin
                  shadow_err = 1'b1;
               end else begin
                  case (fn)
                     FN_NUM: push_value(opnd);
                     FN_POP: shadow_depth--;
                     FN_INV: begin
                        r = -pop_value();
                        if (r > MAX31) shadow_err = 1'b1;
                        else push_value(r);
                     end
                     FN_DUP: push_value(shadow_stack[slot(shadow_depth - 1)]);
                     FN_SWP: begin
                        b = pop_value();
                        a = pop_value();
                        push_value(b);
                        push_value(a);
                     end
                     default: begin
                        b = pop_value();
                        a = pop_value();
                        if (fn == FN_DIV || fn == FN_MOD) begin
                           if (b == 0) begin
                              shadow_err = 1'b1;
                           end else begin
                              // longint division truncates, remainder follows dividend
                              r = (fn == FN_DIV) ? a / b : a % b;
                              if (r > MAX31 || r < MIN31) shadow_err = 1'b1;
                              else push_value(r);
                           end
                        end else begin
                           r = (fn == FN_ADD) ? a + b : (fn == FN_SUB) ? a - b : a * b;
                           if (((r < 0) ? -r : r) > longint'(shadow_limit)) shadow_err = 1'b1;
                           else push_value(r);
                        end
                     end
                  endcase
               end
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- driving
   task automatic send_instr(input logic [FUNC_W-1:0] fn,
                             input logic signed [VALUE_W-1:0] opnd);
      int idle;
      idle = 0;
      while ($urandom_range(99) < sender_idle_pct) idle++;
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= fn;
      req_operand <= opnd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      execute_instr(fn, opnd);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_finish.size() != 0) @(posedge clock);
      // a trailing DIV or MOD may still be running with nothing expected
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      drain_results();
      csr_valid           <= 1'b1;
      csr_magnitude_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      shadow_limit  = value;
   endtask

   // receiver: random stall, plus a long hold-off whenever one is requested
   initial begin : receiver_stall
      int served;
      int left;
      served = 0;
      left   = 0;
      forever begin
         @(posedge clock);
         if (served != hold_requests) begin
            served = hold_requests;
            left   = HOLD_OFF_CYCLES;
         end
         if (left > 0) begin
            left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      finish_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_finish.size() == 0) begin
            $error("unexpected result transaction: value %0d, error %0b",
                   rsp_result_value, rsp_is_error);
            fail_count++;
         end else begin
            want = pending_finish.pop_front();
            if (rsp_is_error !== want.is_error) begin
               $error("rsp_is_error: expected %0b, got %0b", want.is_error, rsp_is_error);
               fail_count++;
            end
            if (rsp_result_value !== want.value) begin
               $error("rsp_result_value: expected %0d, got %0d",
                      want.value, rsp_result_value);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic logic signed [VALUE_W-1:0] pick_operand();
      int v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = int'($urandom_range(40)) - 20;
         4, 5:       v = int'($urandom_range(200000)) - 100000;
         6:          v = int'($urandom_range(2000000000)) - 1000000000;
         7: begin
            case ($urandom_range(5))
               0:       v = 1000000000;
               1:       v = -1000000000;
               2:       v = 0;
               3:       v = 1;
               4:       v = -1;
               default: v = -1073741824;
            endcase
         end
         8:       v = $urandom;  // any 31-bit pattern, in range or not
         default: v = int'($urandom_range(30000)) - 15000;
      endcase
      return v[VALUE_W-1:0];
   endfunction

   function automatic logic [FUNC_W-1:0] pick_binary();
      case ($urandom_range(5))
         0:       return FN_ADD;
         1:       return FN_SUB;
         2:       return FN_MUL;
         3:       return FN_DIV;
         4:       return FN_MOD;
         default: return FN_SWP;
      endcase
   endfunction

   // mostly ops the current stack depth can serve, some noise
   function automatic logic [FUNC_W-1:0] pick_func();
      int roll;
      logic [FUNC_W-1:0] code;
      roll = $urandom_range(99);
      code = FUNC_W'($urandom_range(15));
      if (roll < 8) return code;
      if (shadow_depth == 0) return FN_NUM;
      if (shadow_depth == 1) begin
         if (roll < 60) return FN_NUM;
         if (roll < 80) return FN_DUP;
         if (roll < 95) return FN_INV;
         return FN_POP;
      end
      if (roll < 33) return FN_NUM;
      if (roll < 90) return pick_binary();
      if (roll < 94) return FN_INV;
      if (roll < 97) return FN_DUP;
      return FN_POP;
   endfunction

   task automatic test_stack_ops();
      int code;
      send_instr(FN_START, 7);
      send_instr(FN_NUM, -3);
      send_instr(FN_SWP, 0);
      send_instr(FN_SUB, 0);
      send_instr(FN_DUP, 0);
      send_instr(FN_MUL, 0);
      send_instr(FN_NUM, -7);
      send_instr(FN_MOD, 0);
      send_instr(FN_NUM, -1);
      send_instr(FN_DIV, 0);
      send_instr(FN_INV, 0);
      send_instr(FN_NUM, 5);
      send_instr(FN_POP, 0);
      for (code = FN_FINISH + 1; code < (1 << FUNC_W); code++) send_instr(FUNC_W'(code), -1);
      send_instr(FN_FINISH, 0);
      send_instr(FN_FINISH, 0);   // state is left alone by a finish
      send_instr(FN_START, 1000000000);
      send_instr(FN_NUM, -1000000000);
      send_instr(FN_ADD, 0);
      send_instr(FN_FINISH, 0);
   endtask

   task automatic test_error_cases();
      // underflow, then ops ignored while the error sticks
      send_instr(FN_START, 1);
      send_instr(FN_POP, 0);
      send_instr(FN_POP, 0);
      send_instr(FN_NUM, 3);
      send_instr(FN_FINISH, 0);
      // negating the most negative value cannot be represented
      send_instr(FN_START, VALUE_MIN);
      send_instr(FN_INV, 0);
      send_instr(FN_FINISH, 0);
      send_instr(FN_START, VALUE_MIN);
      send_instr(FN_NUM, -1);
      send_instr(FN_DIV, 0);
      send_instr(FN_FINISH, 0);
      send_instr(FN_START, 5);
      send_instr(FN_NUM, 0);
      send_instr(FN_MOD, 0);
      send_instr(FN_FINISH, 0);
      send_instr(FN_START, 1000000000);
      send_instr(FN_DUP, 0);
      send_instr(FN_ADD, 0);
      send_instr(FN_FINISH, 0);
      send_instr(FN_START, 1);
      send_instr(FN_POP, 0);
      send_instr(FN_FINISH, 0);   // empty stack
   endtask

   task automatic test_limit_extremes();
      write_limit('0);
      send_instr(FN_START, 0);
      send_instr(FN_NUM, 1);
      send_instr(FN_MUL, 0);
      send_instr(FN_NUM, 1);
      send_instr(FN_ADD, 0);
      send_instr(FN_FINISH, 0);
      write_limit(LIMIT_MAX);
      send_instr(FN_START, 536870912);
      send_instr(FN_NUM, 536870911);
      send_instr(FN_ADD, 0);
      send_instr(FN_FINISH, 0);
      send_instr(FN_NUM, 1);
      send_instr(FN_ADD, 0);
      send_instr(FN_FINISH, 0);
   endtask

   task automatic test_random_programs(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(19) == 0) begin
            send_instr(pick_func(), pick_operand());
            sent++;
         end
         send_instr(FN_START, pick_operand());
         sent++;
         len = $urandom_range(1, 14);
         repeat (len) begin
            send_instr(pick_func(), pick_operand());
            sent++;
         end
         if ($urandom_range(3) != 0) begin
            while (shadow_depth > 1 && !shadow_err) begin
               send_instr(pick_binary(), 0);
               sent++;
            end
         end
         if ($urandom_range(9) != 0) begin
            send_instr(FN_FINISH, pick_operand());
            sent++;
         end
      end
   endtask

   // fills the whole stack, the last entry by a DUP, then pushes past the top
   task automatic test_stack_depth();
      int i;
      send_instr(FN_START, VALUE_W'(int'($urandom_range(2000)) - 1000));
      for (i = 2; i < STACK_DEPTH_DEF; i++) begin
         send_instr(FN_NUM, VALUE_W'(int'($urandom_range(2000)) - 1000));
      end
      send_instr(FN_DUP, 0);
      send_instr(FN_FINISH, 0);
      send_instr(FN_NUM, 1);
      send_instr(FN_FINISH, 0);
   endtask

   task automatic test_backpressure();
      drain_results();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_requests++;
      repeat (8) begin
         send_instr(FN_START, pick_operand());
         send_instr(FN_NUM, pick_operand());
         send_instr(FN_SUB, 0);
         send_instr(FN_FINISH, 0);
      end
      // pause the sender until the receiver has taken everything
      drain_results();
      send_instr(FN_START, pick_operand());
      send_instr(FN_FINISH, 0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_idle_pct    = 12;
      receiver_stall_pct = 64;
      test_stack_ops();
      test_error_cases();
      test_limit_extremes();
      write_limit(LIMIT_RESET);
      test_random_programs(110);
      sender_idle_pct    = 64;
      receiver_stall_pct = 12;
      write_limit(30'd5000);
      test_random_programs(110);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      write_limit(LIMIT_MAX);
      test_random_programs(110);
      test_stack_depth();
      test_backpressure();
      drain_results();
      if (fail_count == 0) begin
         $display("PASS integer_stack_machine");
      end else begin
         $display("FAIL integer_stack_machine");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL integer_stack_machine");
      $finish;
   end

endmodule
